// File: hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

    localparam int DEQ_DEPTH   = 64;
    localparam int VALUE_W     = 32;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_PEEK_FRONT = 3'd4,
        KIND_PEEK_BACK  = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

endpackage

// File: hdl/deq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/double_ended_queue.sv
// Top level of the double-ended queue: index control, RAM and result stage.
//
// Usage: each input transaction carries a request kind (push back, push front,
// pop front, pop back, peek front, peek back) and a value used by pushes.
// Every request returns exactly one result transaction: the value read
// (zero for pushes, errors and unused kinds), a status (done, empty, full)
// and the entry count after the request.
// Pipeline: the entry RAM read and the read stage register at the accepting
// edge; the result register loads from them when the read stage advances.
// Throughput: one request per cycle while o_stall is low, set by the single
// write port and the single read port of the entry RAM, each used at most
// once per request.
// Reset (synchronous, active low) empties the queue at once: head, tail and
// count clear, no clearing pass runs over the RAM, and no result is pending.
// When the receiver stalls, the result register holds; the read stage holds
// behind it (the RAM read data holds since no new read is issued), and
// o_stall rises once the read stage is occupied, so no further request
// enters until the result is taken.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [KIND_W-1:0]          i_kind,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [VALUE_W-1:0]  o_out_value,
    output logic [STATUS_W-1:0]        o_status,
    output logic [COUNT_OUT_W-1:0]     o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // queue indices and count
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    // read stage: RAM read in flight
    logic          r_p_valid;
    logic          r_p_rd, n_p_rd;
    t_status       r_p_status, n_p_status;
    logic [CW-1:0] r_p_count;

    // result stage
    logic                      r_o_valid;
    logic signed [VALUE_W-1:0] r_o_value;
    t_status                   r_o_status;
    logic [COUNT_OUT_W-1:0]    r_o_count;

    logic               in_accept;
    logic               advance;
    logic               is_empty;
    logic               is_full;
    logic [AW-1:0]      head_next, head_prev, tail_next, tail_prev;
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [VALUE_W-1:0] rd_data;

    // move the read stage forward whenever the result register is free or drains
    assign advance   = r_p_valid && (!r_o_valid || !i_stall);
    assign o_stall   = r_p_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == FULL_CNT);

    // circular wrap in both directions, valid for any depth
    assign head_next = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
    assign head_prev = (r_head == '0) ? LAST_SLOT : r_head - AW'(1);
    assign tail_next = (r_tail == LAST_SLOT) ? '0 : r_tail + AW'(1);
    assign tail_prev = (r_tail == '0) ? LAST_SLOT : r_tail - AW'(1);

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_p_rd     = 1'b0;
        n_p_status = STATUS_DONE;
        wr_en      = 1'b0;
        wr_addr    = r_tail;
        rd_addr    = r_head;
        case (t_kind'(i_kind))
            KIND_PUSH_BACK: begin
                if (is_full) begin
                    n_p_status = STATUS_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_tail;
                    n_tail  = tail_next;
                    n_count = r_count + CW'(1);
                end
            end
            KIND_PUSH_FRONT: begin
                if (is_full) begin
                    n_p_status = STATUS_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = head_prev;
                    n_head  = head_prev;
                    n_count = r_count + CW'(1);
                end
            end
            KIND_POP_FRONT: begin
                if (is_empty) begin
                    n_p_status = STATUS_EMPTY;
                end else begin
                    n_p_rd  = 1'b1;
                    rd_addr = r_head;
                    n_head  = head_next;
                    n_count = r_count - CW'(1);
                end
            end
            KIND_POP_BACK: begin
                if (is_empty) begin
                    n_p_status = STATUS_EMPTY;
                end else begin
                    n_p_rd  = 1'b1;
                    rd_addr = tail_prev;
                    n_tail  = tail_prev;
                    n_count = r_count - CW'(1);
                end
            end
            KIND_PEEK_FRONT: begin
                if (is_empty) begin
                    n_p_status = STATUS_EMPTY;
                end else begin
                    n_p_rd  = 1'b1;
                    rd_addr = r_head;
                end
            end
            KIND_PEEK_BACK: begin
                if (is_empty) begin
                    n_p_status = STATUS_EMPTY;
                end else begin
                    n_p_rd  = 1'b1;
                    rd_addr = tail_prev;
                end
            end
            default: begin
                // unused kinds: leave everything, report done
                n_p_status = STATUS_DONE;
            end
        endcase
    end

    // issue the read only on accept so the read data holds while stalled
    assign rd_en = in_accept && n_p_rd;

    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_accept && wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            if (in_accept) begin
                r_p_valid <= 1'b1;
            end else if (advance) begin
                r_p_valid <= 1'b0;
            end
            if (advance) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_p_rd     <= n_p_rd;
            r_p_status <= n_p_status;
            r_p_count  <= n_count;
        end
        if (advance) begin
            r_o_value  <= r_p_rd ? $signed(rd_data) : '0;
            r_o_status <= r_p_status;
            r_o_count  <= COUNT_OUT_W'(r_p_count);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_value   = r_o_value;
    assign o_status      = r_o_status;
    assign o_entry_count = r_o_count;

endmodule
